>>> hdl/lph_pkg.sv
// Shared types and constants for the linear probing hash table unit.
package lph_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned KEY_MAX_BYTES = 8;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned SLOT_OUT_W    = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_state_e;

  typedef struct packed {
    logic [1:0]                 command;
    logic [8*KEY_MAX_BYTES-1:0] key;
    logic [VALUE_W-1:0]         value;
  } lph_in_t;

  typedef struct packed {
    logic                  ok;
    logic [VALUE_W-1:0]    found_value;
    logic [SLOT_OUT_W-1:0] slot;
  } lph_out_t;

endpackage

>>> hdl/lph_hash.sv
// Serial key hash: h = ((h + c) * c) mod SLOTS, one character at a time through multiply, quotient and reduce steps.
module lph_hash #(
  parameter int unsigned SLOTS     = lph_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [8*KEY_BYTES-1:0]     key_i,
  output logic                       done_o,
  output logic [$clog2(SLOTS)-1:0]   hash_o
);
  import lph_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned SUM_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int unsigned X_W   = SUM_W + 8;
  localparam int unsigned K_W   = X_W + IDX_W;
  localparam int unsigned P_W   = X_W + K_W;
  localparam logic [K_W-1:0] RECIP = K_W'((64'd1 << K_W) / SLOTS);

  typedef enum logic [3:0] {
    HS_IDLE = 4'b0001,
    HS_MUL  = 4'b0010,
    HS_QUO  = 4'b0100,
    HS_MOD  = 4'b1000
  } hash_state_e;

  hash_state_e      hs_q, hs_d;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] h_q;
  logic [X_W-1:0]   x_q;
  logic [X_W-1:0]   q_q;

  logic [7:0]       chr;
  logic [SUM_W-1:0] sum;
  logic [X_W-1:0]   x_next;
  logic [P_W-1:0]   prod;
  logic [X_W-1:0]   qs;
  logic [X_W-1:0]   rem;
  logic [IDX_W-1:0] h_red;

  assign chr    = key_q[7:0];
  assign sum    = SUM_W'(h_q) + SUM_W'(chr);
  assign x_next = X_W'(sum) * X_W'(chr);
  assign prod   = P_W'(x_q) * P_W'(RECIP);
  assign qs     = q_q * X_W'(SLOTS);
  assign rem    = x_q - qs;
  assign h_red  = (rem >= X_W'(SLOTS)) ? IDX_W'(rem - X_W'(SLOTS)) : IDX_W'(rem);

  assign done_o = (hs_q == HS_MUL) && (chr == 8'd0);
  assign hash_o = h_q;

  always_comb begin
    hs_d = hs_q;
    unique case (hs_q)
      HS_IDLE: if (start_i) hs_d = HS_MUL;
      HS_MUL:  hs_d = (chr == 8'd0) ? HS_IDLE : HS_QUO;
      HS_QUO:  hs_d = HS_MOD;
      HS_MOD:  hs_d = HS_MUL;
      default: hs_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= HS_IDLE;
    end else begin
      hs_q <= hs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_q == HS_IDLE && start_i) begin
      key_q <= key_i;
      h_q   <= '0;
    end
    if (hs_q == HS_MUL && chr != 8'd0) begin
      x_q   <= x_next;
      key_q <= key_q >> 8;
    end
    if (hs_q == HS_QUO) begin
      q_q <= prod[K_W +: X_W];
    end
    if (hs_q == HS_MOD) begin
      h_q <= h_red;
    end
  end

  hash_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hs_q == HS_MUL)
    else $error("hash done outside multiply step");

  hash_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hs_q == HS_IDLE && start_i) |=> hs_q == HS_MUL)
    else $error("hash did not start");

  hash_mod_follows_quo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hs_q == HS_MOD |-> $past(hs_q) == HS_QUO)
    else $error("hash reduction out of order");

endmodule

>>> hdl/linear_probe_hash_table_unit.sv
// Linear probing hash table unit: top level with the slot memory and probe control.
//
// Open-addressing table of SLOTS entries with tombstones, kept in synchronous
// slot memories (status, key, value) with a registered read. After reset the unit
// runs a clearing pass over every slot of the status store and accepts no item
// until it ends. Each command is then taken one at a time: the key is hashed
// serially one character at a time, and the probe then reads one slot per cycle
// while the output register is free, so the serial hash and the probe loop
// together set the rate, and no new item is accepted until the current command
// has finished its probe. A finished result waits in the output register while
// the next item is accepted.
module linear_probe_hash_table_unit #(
  parameter int unsigned SLOTS     = lph_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lph_pkg::lph_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lph_pkg::lph_out_t out_data_o
);
  import lph_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned KEY_W = 8 * KEY_BYTES;

  typedef enum logic [3:0] {
    STATE_CLEAR = 4'b0001,
    STATE_IDLE  = 4'b0010,
    STATE_HASH  = 4'b0100,
    STATE_PROBE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] val_q;
  logic               out_valid_q, out_valid_d;
  lph_out_t           out_q, out_d;

  logic [1:0]         status_mem [SLOTS];
  logic [KEY_W-1:0]   key_mem    [SLOTS];
  logic [VALUE_W-1:0] value_mem  [SLOTS];
  logic [1:0]         rd_status_q;
  logic [KEY_W-1:0]   rd_key_q;
  logic [VALUE_W-1:0] rd_value_q;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               st_we;
  logic [1:0]         st_wdata;
  logic               ent_we;

  logic [KEY_W-1:0]   key_trim;
  logic               alive;
  logic               in_fire;
  logic               hash_done;
  logic [IDX_W-1:0]   hash_val;

  logic               out_free;
  logic               is_ins;
  logic               is_srch;
  logic               last;
  logic               hit_ins;
  logic               hit_srch;
  logic               stop;
  logic               ok;
  logic [IDX_W-1:0]   idx_next;
  logic [IDX_W+3:0]   slot_ext;

  assign in_ready_o  = (state_q == STATE_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    key_trim = '0;
    alive    = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      alive = alive && (in_data_i.key[8*i +: 8] != 8'd0);
      if (alive) key_trim[8*i +: 8] = in_data_i.key[8*i +: 8];
    end
  end

  lph_hash #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   (key_trim),
    .done_o  (hash_done),
    .hash_o  (hash_val)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign is_ins   = (cmd_q == CMD_INSERT);
  assign is_srch  = (cmd_q == CMD_LOOKUP) || (cmd_q == CMD_DELETE);
  assign last     = (cnt_q == IDX_W'(SLOTS - 1));
  assign hit_ins  = is_ins && (rd_status_q != SLOT_USED);
  assign hit_srch = is_srch && (rd_status_q == SLOT_USED) && (rd_key_q == key_q);
  assign ok       = hit_ins || hit_srch;
  assign stop     = !(is_ins || is_srch) || ok || last
                    || (is_srch && rd_status_q == SLOT_EMPTY);
  assign idx_next = (idx_q == IDX_W'(SLOTS - 1)) ? '0 : idx_q + 1'b1;
  assign slot_ext = (IDX_W + 4)'(idx_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_addr     = idx_q;
    wr_addr     = idx_q;
    st_we       = 1'b0;
    st_wdata    = SLOT_EMPTY;
    ent_we      = 1'b0;
    unique case (state_q)
      STATE_CLEAR: begin
        wr_addr = clr_q;
        st_we   = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IDX_W'(SLOTS - 1)) state_d = STATE_IDLE;
      end
      STATE_IDLE: begin
        if (in_fire) state_d = STATE_HASH;
      end
      STATE_HASH: begin
        rd_addr = hash_val;
        if (hash_done) begin
          idx_d   = hash_val;
          cnt_d   = '0;
          state_d = STATE_PROBE;
        end
      end
      STATE_PROBE: begin
        if (out_free) begin
          if (stop) begin
            out_valid_d       = 1'b1;
            out_d.ok          = ok;
            out_d.found_value = hit_srch ? rd_value_q : '0;
            out_d.slot        = ok ? slot_ext[3:0] : '0;
            st_we             = hit_ins || (hit_srch && cmd_q == CMD_DELETE);
            st_wdata          = hit_ins ? SLOT_USED : SLOT_DELETED;
            ent_we            = hit_ins;
            state_d           = STATE_IDLE;
          end else begin
            rd_addr = idx_next;
            idx_d   = idx_next;
            cnt_d   = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = STATE_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
    if (in_fire) begin
      cmd_q <= in_data_i.command;
      key_q <= key_trim;
      val_q <= in_data_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) status_mem[wr_addr] <= st_wdata;
    if (ent_we) begin
      key_mem[wr_addr]   <= key_q;
      value_mem[wr_addr] <= val_q;
    end
    rd_status_q <= status_mem[rd_addr];
    rd_key_q    <= key_mem[rd_addr];
    rd_value_q  <= value_mem[rd_addr];
  end

  result_from_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == STATE_PROBE)
    else $error("result loaded outside probe");

  miss_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.ok) |-> (out_data_o.slot == '0
      && out_data_o.found_value == '0))
    else $error("miss carries nonzero fields");

  write_when_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_we || ent_we) |-> (state_q == STATE_CLEAR || state_q == STATE_PROBE))
    else $error("slot memory written outside clear or probe");

  accept_starts_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == STATE_HASH)
    else $error("accepted item did not start hashing");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the linear probing hash table unit: random and directed commands checked against a table model.
module tb;
  import lph_pkg::*;

  localparam int unsigned SLOTS       = SLOTS_DEF;
  localparam int unsigned KEY_BYTES   = KEY_BYTES_DEF;
  localparam logic [1:0]  CMD_UNKNOWN = 2'd3;
  localparam int unsigned RAND_CMDS   = 1450;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 60;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  lph_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  lph_out_t out_data_o;

  lph_in_t     pending_cmds[$];
  lph_out_t    awaited_results[$];
  slot_state_e tbl_state[SLOTS];
  logic [63:0] tbl_key[SLOTS];
  logic [15:0] tbl_value[SLOTS];
  int unsigned cmds_taken = 0;
  int unsigned cmds_total = 0;
  int unsigned quiet_cycles = 0;
  bit          failed = 1'b0;

  linear_probe_hash_table_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [63:0] key_chars(input logic [63:0] raw, output int unsigned start);
    logic [63:0] kept;
    logic [7:0]  c;
    int unsigned h;
    bit          ended;
    kept  = '0;
    h     = 0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      c = raw[8*i +: 8];
      if (c == 8'd0) ended = 1'b1;
      if (!ended) begin
        kept[8*i +: 8] = c;
        h = ((h + c) * c) % SLOTS;
      end
    end
    start = h;
    return kept;
  endfunction

  function automatic lph_out_t run_table_cmd(input lph_in_t c);
    lph_out_t    r;
    logic [63:0] k;
    int unsigned h;
    int unsigned idx;
    bit          done;
    r    = '0;
    k    = key_chars(c.key, h);
    done = 1'b0;
    if (c.command == CMD_INSERT) begin
      for (int i = 0; i < SLOTS && !done; i++) begin
        idx = (h + i) % SLOTS;
        if (tbl_state[idx] != SLOT_USED) begin
          tbl_state[idx] = SLOT_USED;
          tbl_key[idx]   = k;
          tbl_value[idx] = c.value;
          r.ok           = 1'b1;
          r.slot         = SLOT_OUT_W'(idx);
          done           = 1'b1;
        end
      end
    end else if (c.command == CMD_LOOKUP || c.command == CMD_DELETE) begin
      for (int i = 0; i < SLOTS && !done; i++) begin
        idx = (h + i) % SLOTS;
        if (tbl_state[idx] == SLOT_EMPTY) begin
          done = 1'b1;
        end else if (tbl_state[idx] == SLOT_USED && tbl_key[idx] == k) begin
          r.ok          = 1'b1;
          r.found_value = tbl_value[idx];
          r.slot        = SLOT_OUT_W'(idx);
          if (c.command == CMD_DELETE) tbl_state[idx] = SLOT_DELETED;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] pool_key(input int unsigned n);
    logic [63:0] k;
    logic [7:0]  c;
    int unsigned len;
    k   = '0;
    len = 1 + (n % 8);
    for (int j = 0; j < 8; j++) begin
      if (j < len) begin
        c = 8'(n * 37 + j * 53 + 11);
        if (n % 3 == 0) c[7] = 1'b1;
        if (c == 8'd0) c = 8'h5a;
        k[8*j +: 8] = c;
      end
    end
    return k;
  endfunction

  // fill the bytes above the terminator with junk
  function automatic logic [63:0] add_junk(input logic [63:0] k);
    logic [63:0] r;
    bit          past;
    r    = k;
    past = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (past) r[8*j +: 8] = 8'($urandom);
      if (k[8*j +: 8] == 8'd0) past = 1'b1;
    end
    return r;
  endfunction

  function automatic lph_in_t make_cmd(input logic [1:0] op, input logic [63:0] k,
                                       input logic [15:0] v);
    lph_in_t c;
    c.command = op;
    c.key     = k;
    c.value   = v;
    return c;
  endfunction

  function automatic int unsigned idle_pct();
    if (cmds_taken < 400) return 0;
    if (cmds_taken < 750) return 65;
    if (cmds_taken < 1100) return 0;
    return 16;
  endfunction

  function automatic int unsigned stall_pct();
    if (cmds_taken < 750) return 0;
    if (cmds_taken < 1100) return 65;
    return 16;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        awaited_results.push_back(run_table_cmd(in_data_i));
        cmds_taken <= cmds_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct()) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_cmds.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no command waiting: ok %0d value %h slot %0d",
                   $time, out_data_o.ok, out_data_o.found_value, out_data_o.slot);
          failed = 1'b1;
        end else if (out_data_o.ok !== awaited_results[0].ok ||
                     out_data_o.found_value !== awaited_results[0].found_value ||
                     out_data_o.slot !== awaited_results[0].slot) begin
          $display("%0t: mismatch: expected ok %0d value %h slot %0d, got ok %0d value %h slot %0d",
                   $time, awaited_results[0].ok, awaited_results[0].found_value,
                   awaited_results[0].slot, out_data_o.ok, out_data_o.found_value,
                   out_data_o.slot);
          failed = 1'b1;
          void'(awaited_results.pop_front());
        end else begin
          void'(awaited_results.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct());
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned ins_w;
    int unsigned look_w;
    int unsigned del_w;
    logic [1:0]  op;
    logic [63:0] k;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end

    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'h41, 16'h0001));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h0, 16'hffff));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, 64'hdead_beef_0000_0000, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, '1, 16'h0000));
    pending_cmds.push_back(make_cmd(CMD_INSERT, '1, 16'h1234));
    pending_cmds.push_back(make_cmd(CMD_DELETE, '1, 16'hffff));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, '1, 16'h0));
    pending_cmds.push_back(make_cmd(CMD_UNKNOWN, '1, 16'hffff));
    for (int i = 0; i < 14; i++) begin
      pending_cmds.push_back(make_cmd(CMD_INSERT, pool_key(i), 16'($urandom)));
    end
    pending_cmds.push_back(make_cmd(CMD_INSERT, pool_key(14), 16'h5555));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, pool_key(20), 16'h0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, add_junk(pool_key(3)), 16'h0));

    for (int n = 0; n < RAND_CMDS; n++) begin
      if ((n / 60) % 2 == 0) begin
        ins_w  = 50;
        look_w = 25;
        del_w  = 20;
      end else begin
        ins_w  = 20;
        look_w = 30;
        del_w  = 45;
      end
      roll = $urandom_range(99);
      if (roll < ins_w) op = CMD_INSERT;
      else if (roll < ins_w + look_w) op = CMD_LOOKUP;
      else if (roll < ins_w + look_w + del_w) op = CMD_DELETE;
      else op = CMD_UNKNOWN;
      roll = $urandom_range(99);
      if (roll < 10) k = {$urandom, $urandom};
      else if (roll < 15) k = '0;
      else k = pool_key($urandom_range(23));
      if ($urandom_range(3) == 0) k = add_junk(k);
      pending_cmds.push_back(make_cmd(op, k, 16'($urandom)));
    end
    cmds_total = pending_cmds.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_taken != cmds_total) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (!failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
